>>> hw/rtl/owm_pkg.sv
// Package with the shared types, codes and phase functions of the one-wire byte engine.
`default_nettype none

package owm_pkg;

  // Command codes carried in the op field of an input beat.
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } owm_op_t;

  // Bus sequencing phases.
  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_RPRE  = 4'd1,
    PH_RLOW  = 4'd2,
    PH_RWAIT = 4'd3,
    PH_RREC  = 4'd4,
    PH_WPRE  = 4'd5,
    PH_WLOW  = 4'd6,
    PH_WREL  = 4'd7,
    PH_WGAP  = 4'd8,
    PH_DPRE  = 4'd9,
    PH_DLOW  = 4'd10,
    PH_DSMP  = 4'd11,
    PH_DTAIL = 4'd12
  } owm_phase_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_RESET_LOW      = 3'd0,
    REG_RESET_RECOVERY = 3'd1,
    REG_ZERO_LOW       = 3'd2,
    REG_ONE_LOW        = 3'd3,
    REG_ONE_RELEASE    = 3'd4,
    REG_READ_LOW       = 3'd5,
    REG_READ_SAMPLE    = 3'd6,
    REG_READ_TAIL      = 3'd7
  } owm_reg_t;

  localparam int TICK_W = 10;
  localparam int SLOT_W = 8;
  localparam int BYTE_W = 8;
  localparam int BIT_W  = 3;

  localparam logic [TICK_W-1:0] RESET_PRE_TICKS = 10'd20;
  localparam logic [TICK_W-1:0] SLOT_PRE_TICKS  = 10'd1;
  localparam logic [TICK_W-1:0] ZERO_REL_TICKS  = 10'd1;
  localparam logic [TICK_W-1:0] WRITE_GAP_TICKS = 10'd10;
  localparam logic [BIT_W-1:0]  LAST_BIT        = 3'd7;

  localparam logic [TICK_W-1:0] RESET_LOW_DEF      = 10'd550;
  localparam logic [TICK_W-1:0] RESET_RECOVERY_DEF = 10'd500;
  localparam logic [SLOT_W-1:0] ZERO_LOW_DEF       = 8'd55;
  localparam logic [SLOT_W-1:0] ONE_LOW_DEF        = 8'd5;
  localparam logic [SLOT_W-1:0] ONE_RELEASE_DEF    = 8'd55;
  localparam logic [SLOT_W-1:0] READ_LOW_DEF       = 8'd4;
  localparam logic [SLOT_W-1:0] READ_SAMPLE_DEF    = 8'd8;
  localparam logic [SLOT_W-1:0] READ_TAIL_DEF      = 8'd64;

  // A phase end can fall through at most this many zero-length phases.
  localparam int ENTER_STEPS = 4;

  typedef struct packed {
    logic [TICK_W-1:0] reset_low;
    logic [TICK_W-1:0] reset_recovery;
    logic [SLOT_W-1:0] zero_low;
    logic [SLOT_W-1:0] one_low;
    logic [SLOT_W-1:0] one_release;
    logic [SLOT_W-1:0] read_low;
    logic [SLOT_W-1:0] read_sample;
    logic [SLOT_W-1:0] read_tail;
  } owm_cfg_t;

  typedef struct packed {
    owm_phase_t        phase;
    logic [TICK_W-1:0] tick_count;
    logic [BYTE_W-1:0] shift_byte;
    logic [BIT_W-1:0]  bit_index;
    logic [BYTE_W-1:0] read_byte;
  } owm_state_t;

  typedef struct packed {
    logic              drive_low;
    logic              busy;
    logic              done;
    logic [BYTE_W-1:0] read_data;
  } owm_res_t;

  // Length of a phase in ticks; zero means the phase is skipped.
  function automatic logic [TICK_W-1:0] phase_len(owm_phase_t p, logic one, owm_cfg_t c);
    logic [TICK_W-1:0] len;
    len = '0;
    unique case (p)
      PH_RPRE:  len = RESET_PRE_TICKS;
      PH_RLOW:  len = c.reset_low;
      PH_RREC:  len = c.reset_recovery;
      PH_WPRE:  len = SLOT_PRE_TICKS;
      PH_WLOW:  len = {2'b00, (one ? c.one_low : c.zero_low)};
      PH_WREL:  len = one ? {2'b00, c.one_release} : ZERO_REL_TICKS;
      PH_WGAP:  len = WRITE_GAP_TICKS;
      PH_DPRE:  len = SLOT_PRE_TICKS;
      PH_DLOW:  len = {2'b00, c.read_low};
      PH_DSMP:  len = {2'b00, c.read_sample};
      PH_DTAIL: len = {2'b00, c.read_tail};
      default:  len = '0;
    endcase
    return len;
  endfunction

  // Work done when a phase runs out, and the phase that follows it.
  function automatic owm_state_t end_phase(owm_state_t s, logic bus);
    owm_state_t r;
    r = s;
    unique case (s.phase)
      PH_RPRE:  r.phase = PH_RLOW;
      PH_RLOW:  r.phase = PH_RWAIT;
      PH_RWAIT: r.phase = PH_RREC;
      PH_WPRE:  r.phase = PH_WLOW;
      PH_WLOW:  r.phase = PH_WREL;
      PH_WREL: begin
        if (s.bit_index == LAST_BIT) begin
          r.phase = PH_WGAP;
        end else begin
          r.bit_index  = s.bit_index + 3'd1;
          r.shift_byte = {1'b0, s.shift_byte[BYTE_W-1:1]};
          r.phase      = PH_WPRE;
        end
      end
      PH_DPRE:  r.phase = PH_DLOW;
      PH_DLOW:  r.phase = PH_DSMP;
      PH_DSMP: begin
        r.shift_byte = {bus, s.shift_byte[BYTE_W-1:1]};
        r.phase      = PH_DTAIL;
      end
      PH_DTAIL: begin
        if (s.bit_index == LAST_BIT) begin
          r.read_byte = s.shift_byte;
          r.phase     = PH_IDLE;
        end else begin
          r.bit_index = s.bit_index + 3'd1;
          r.phase     = PH_DPRE;
        end
      end
      default:  r.phase = PH_IDLE;
    endcase
    return r;
  endfunction

  // Enter a phase, falling through any phase whose length is zero.
  function automatic owm_state_t enter_phase(owm_state_t s, logic bus, owm_cfg_t c);
    owm_state_t        r;
    logic              settled;
    logic [TICK_W-1:0] len;
    r       = s;
    settled = 1'b0;
    len     = '0;
    for (int i = 0; i < ENTER_STEPS; i++) begin
      if (!settled) begin
        if (r.phase == PH_IDLE || r.phase == PH_RWAIT) begin
          r.tick_count = '0;
          settled      = 1'b1;
        end else begin
          len = phase_len(r.phase, r.shift_byte[0], c);
          if (len != '0) begin
            r.tick_count = len;
            settled      = 1'b1;
          end else begin
            r = end_phase(r, bus);
          end
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/owm_cfg.sv
// Timing configuration registers of the one-wire byte engine.
`default_nettype none

module owm_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [2:0]                cfg_index,
  input  wire logic [owm_pkg::TICK_W-1:0] cfg_data,
  output owm_pkg::owm_cfg_t              cfg
);
  import owm_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low      <= RESET_LOW_DEF;
      cfg.reset_recovery <= RESET_RECOVERY_DEF;
      cfg.zero_low       <= ZERO_LOW_DEF;
      cfg.one_low        <= ONE_LOW_DEF;
      cfg.one_release    <= ONE_RELEASE_DEF;
      cfg.read_low       <= READ_LOW_DEF;
      cfg.read_sample    <= READ_SAMPLE_DEF;
      cfg.read_tail      <= READ_TAIL_DEF;
    end else if (cfg_valid) begin
      unique case (owm_reg_t'(cfg_index))
        REG_RESET_LOW:      cfg.reset_low      <= cfg_data;
        REG_RESET_RECOVERY: cfg.reset_recovery <= cfg_data;
        REG_ZERO_LOW:       cfg.zero_low       <= cfg_data[SLOT_W-1:0];
        REG_ONE_LOW:        cfg.one_low        <= cfg_data[SLOT_W-1:0];
        REG_ONE_RELEASE:    cfg.one_release    <= cfg_data[SLOT_W-1:0];
        REG_READ_LOW:       cfg.read_low       <= cfg_data[SLOT_W-1:0];
        REG_READ_SAMPLE:    cfg.read_sample    <= cfg_data[SLOT_W-1:0];
        REG_READ_TAIL:      cfg.read_tail      <= cfg_data[SLOT_W-1:0];
        default:            cfg.reset_low      <= cfg.reset_low;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/owm_seq.sv
// Bus phase sequencer: holds the command state and advances it by one tick per enable.
`default_nettype none

module owm_seq (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic [1:0]                op,
  input  wire logic [owm_pkg::BYTE_W-1:0] write_data,
  input  wire logic                      bus_level,
  input  wire owm_pkg::owm_cfg_t         cfg,
  output owm_pkg::owm_res_t              res
);
  import owm_pkg::*;

  owm_state_t state;
  owm_state_t cmd_state;
  owm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_IDLE, default: '0};
    end else if (en) begin
      state <= state_next;
    end
  end

  // A command is taken only while idle; its tick is the first tick of the command.
  always_comb begin
    cmd_state = state;
    if (state.phase == PH_IDLE) begin
      cmd_state.bit_index = '0;
      unique case (owm_op_t'(op))
        OP_RESET: begin
          cmd_state.phase      = PH_RPRE;
          cmd_state.tick_count = RESET_PRE_TICKS;
        end
        OP_WRITE: begin
          cmd_state.phase      = PH_WPRE;
          cmd_state.shift_byte = write_data;
          cmd_state.tick_count = SLOT_PRE_TICKS;
        end
        OP_READ: begin
          cmd_state.phase      = PH_DPRE;
          cmd_state.shift_byte = '0;
          cmd_state.tick_count = SLOT_PRE_TICKS;
        end
        default: cmd_state = state;
      endcase
    end
  end

  // Next state: count down the current phase and move on when it runs out.
  always_comb begin
    owm_state_t dec;
    dec        = cmd_state;
    state_next = cmd_state;
    if (cmd_state.phase == PH_RWAIT) begin
      if (!bus_level) begin
        state_next = enter_phase(end_phase(cmd_state, bus_level), bus_level, cfg);
      end
    end else if (cmd_state.phase != PH_IDLE) begin
      dec.tick_count = cmd_state.tick_count - 10'd1;
      if (dec.tick_count == '0) begin
        state_next = enter_phase(end_phase(dec, bus_level), bus_level, cfg);
      end else begin
        state_next = dec;
      end
    end
  end

  // Outputs of this tick.
  always_comb begin
    res.busy      = (cmd_state.phase != PH_IDLE);
    res.drive_low = (cmd_state.phase == PH_RLOW) || (cmd_state.phase == PH_WLOW) ||
                    (cmd_state.phase == PH_DLOW);
    res.done      = res.busy && (state_next.phase == PH_IDLE);
    res.read_data = state_next.read_byte;
  end

endmodule

`default_nettype wire

>>> hw/rtl/one_wire_master_byte_engine.sv
// Top level of the one-wire bus master byte engine: stream ports, tick register, result register.
// Path: a tick beat is taken into the tick register, the sequencer works on the
//   tick register and its result is captured in the result register.
// Throughput is one tick beat per cycle while results are taken; the sequencer settles in one pass.
// Back pressure on the result side stalls the tick register and so the sequencer.
// Reset (rst, synchronous, active high) empties both registers, returns the sequencer to idle
//   with a cleared read byte, and loads the timing registers with their default values.
`default_nettype none

module one_wire_master_byte_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  // Tick beats in.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // [1:0] op, [9:2] write_data, [10] bus_level, rest zero
  // Result beats out.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,  // [0] drive_low, [1] busy_res, [2] done_res,
                                     // [10:3] read_data, rest zero
  // Timing register writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);
  import owm_pkg::*;

  // Tick register: holds one beat until the sequencer has consumed it.
  logic              in_valid;
  logic [1:0]        in_op;
  logic [BYTE_W-1:0] in_data;
  logic              in_bus;

  // The sequencer steps whenever a tick is held and the result register can take its result.
  logic     advance;
  owm_cfg_t cfg;
  owm_res_t res;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= s_tdata[1:0];
      in_data <= s_tdata[9:2];
      in_bus  <= s_tdata[10];
    end
  end

  owm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  owm_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .op         (in_op),
    .write_data (in_data),
    .bus_level  (in_bus),
    .cfg        (cfg),
    .res        (res)
  );

  // Result register: a new result is captured in the same cycle that the waiting beat leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {5'd0, res.read_data, res.done, res.busy, res.drive_low};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/owm_checker.sv
// Port-level checker for the one-wire byte engine, bound to its top level.
`default_nettype none

module owm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic        s_tready
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // A command can only finish on a tick where it is in progress.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[1])
    else $error("done without busy");

  // The bus is only pulled low by a running command.
  a_drive_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[1])
    else $error("bus driven while idle");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result beat present after reset");

  // The tick side is free whenever no result waits.
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("tick side stalled with an empty result register");

endmodule

bind one_wire_master_byte_engine owm_checker u_owm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .s_tready (s_tready)
);

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the one-wire bus master byte engine.
`timescale 1ns / 100ps

module tb;
  import owm_pkg::*;

  // One result beat, unpacked from m_tdata.
  typedef struct packed {
    logic       drive_low;
    logic       busy;
    logic       done;
    logic [7:0] rdata;
  } bus_result_t;

  // One row of the opening plan: a tick held for reps beats. When typed is set the
  // expected result is the one written in the row, otherwise the bus model supplies it.
  typedef struct packed {
    owm_op_t     op;
    logic [7:0]  wbyte;
    logic        bus;
    logic [7:0]  reps;
    logic        typed;
    bus_result_t want;
  } plan_row_t;

  typedef enum {TS_ZERO, TS_SMALL, TS_MIXED, TS_MAX} timing_style_t;

  localparam int PLAN_ROWS     = 9;
  localparam int SETTLE_CYCLES = 4;    // result path is two registers deep
  localparam int DRAIN_CYCLES  = 8;
  localparam int BACKLOG_AFTER = 500;  // result beats seen before the long hold
  localparam int BACKLOG_HOLD  = 300;  // cycles the result side stays stalled

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [9:0]  cfg_data;

  one_wire_master_byte_engine dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Opening plan, run with every timing register at zero. With zero timings a read
  // slot is a single released tick that also samples the bus, a write-one slot is a
  // single released tick, and a reset is the 20 released ticks before the pulse plus
  // the presence wait. The bus is never pulled low under these settings, so most
  // rows can be read off directly.
  plan_row_t opening_plan [PLAN_ROWS] = '{
    // Idle tick right after reset: nothing driven, read byte still clear.
    '{OP_NONE,  8'h00, 1'b1, 8'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 8'h00}},
    // Read with the bus high; the repeated read command is ignored while busy.
    '{OP_READ,  8'hFF, 1'b1, 8'd7,  1'b1, '{1'b0, 1'b1, 1'b0, 8'h00}},
    // Eighth slot finishes the read with all ones; the write offered here is ignored.
    '{OP_WRITE, 8'h00, 1'b1, 8'd1,  1'b1, '{1'b0, 1'b1, 1'b1, 8'hFF}},
    '{OP_NONE,  8'h00, 1'b0, 8'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 8'hFF}},
    // Write of all ones: eight one-tick slots, then the ten-tick gap.
    '{OP_WRITE, 8'hFF, 1'b0, 8'd17, 1'b1, '{1'b0, 1'b1, 1'b0, 8'hFF}},
    '{OP_RESET, 8'h00, 1'b1, 8'd1,  1'b1, '{1'b0, 1'b1, 1'b1, 8'hFF}},
    // Reset: the released lead-in, then one presence-wait tick with the bus high.
    '{OP_RESET, 8'h00, 1'b1, 8'd21, 1'b0, '{1'b0, 1'b0, 1'b0, 8'h00}},
    // Presence pulse ends the wait; zero recovery finishes the reset on this tick.
    '{OP_NONE,  8'h00, 1'b0, 8'd1,  1'b0, '{1'b0, 1'b0, 1'b0, 8'h00}},
    '{OP_NONE,  8'h00, 1'b1, 8'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 8'hFF}}
  };

  // Bus model state, shadowing the sequencer inside the block.
  owm_phase_t  seq_phase;
  logic [9:0]  ticks_left;
  logic [7:0]  shift_reg;
  logic [2:0]  bit_pos;
  logic [7:0]  last_read;
  logic [9:0]  timing [0:7];

  bus_result_t tick_results [$];   // expected result beats, oldest first
  bus_result_t seen_beat;
  bus_result_t wanted_beat;
  int          mismatches;
  int          beats_seen;
  int          send_calm;
  int          recv_calm;
  bit          backlog_done;

  // ---------------------------------------------------------------------------
  // Bus model
  // ---------------------------------------------------------------------------

  // Number of ticks a phase lasts under the current timing; zero means skipped.
  function automatic logic [9:0] phase_span(owm_phase_t p);
    logic [9:0] n;
    case (p)
      PH_RPRE:  n = RESET_PRE_TICKS;
      PH_RLOW:  n = timing[REG_RESET_LOW];
      PH_RREC:  n = timing[REG_RESET_RECOVERY];
      PH_WPRE:  n = SLOT_PRE_TICKS;
      PH_WLOW:  n = shift_reg[0] ? timing[REG_ONE_LOW] : timing[REG_ZERO_LOW];
      PH_WREL:  n = shift_reg[0] ? timing[REG_ONE_RELEASE] : ZERO_REL_TICKS;
      PH_WGAP:  n = WRITE_GAP_TICKS;
      PH_DPRE:  n = SLOT_PRE_TICKS;
      PH_DLOW:  n = timing[REG_READ_LOW];
      PH_DSMP:  n = timing[REG_READ_SAMPLE];
      PH_DTAIL: n = timing[REG_READ_TAIL];
      default:  n = 10'd0;
    endcase
    return n;
  endfunction

  // Wraps up a phase (bit shifting, sampling, byte capture) and names the next one.
  function automatic owm_phase_t finish_phase(owm_phase_t p, logic bus);
    owm_phase_t nxt;
    case (p)
      PH_RPRE:  nxt = PH_RLOW;
      PH_RLOW:  nxt = PH_RWAIT;
      PH_RWAIT: nxt = PH_RREC;
      PH_WPRE:  nxt = PH_WLOW;
      PH_WLOW:  nxt = PH_WREL;
      PH_WREL: begin
        if (bit_pos == LAST_BIT) begin
          nxt = PH_WGAP;
        end else begin
          bit_pos   = bit_pos + 3'd1;
          shift_reg = shift_reg >> 1;
          nxt       = PH_WPRE;
        end
      end
      PH_DPRE:  nxt = PH_DLOW;
      PH_DLOW:  nxt = PH_DSMP;
      PH_DSMP: begin
        shift_reg = {bus, shift_reg[7:1]};
        nxt       = PH_DTAIL;
      end
      PH_DTAIL: begin
        if (bit_pos == LAST_BIT) begin
          last_read = shift_reg;
          nxt       = PH_IDLE;
        end else begin
          bit_pos = bit_pos + 3'd1;
          nxt     = PH_DPRE;
        end
      end
      default:  nxt = PH_IDLE;
    endcase
    return nxt;
  endfunction

  // Moves into a phase, passing straight through every phase of zero length.
  function automatic void enter_from(owm_phase_t p, logic bus);
    owm_phase_t cur;
    logic [9:0] n;
    bit         settled;
    cur     = p;
    settled = 1'b0;
    while (!settled) begin
      seq_phase = cur;
      if (cur == PH_IDLE || cur == PH_RWAIT) begin
        ticks_left = 10'd0;
        settled    = 1'b1;
      end else begin
        n = phase_span(cur);
        if (n != 10'd0) begin
          ticks_left = n;
          settled    = 1'b1;
        end else begin
          cur = finish_phase(cur, bus);
        end
      end
    end
  endfunction

  // Advances the model by one tick and returns the result beat it should produce.
  function automatic bus_result_t predict_tick(owm_op_t op, logic [7:0] wbyte, logic bus);
    bus_result_t r;
    r.drive_low = 1'b0;
    r.busy      = 1'b0;
    r.done      = 1'b0;
    // A command only starts from idle, and its first tick is this one.
    if (seq_phase == PH_IDLE && op != OP_NONE) begin
      bit_pos = 3'd0;
      case (op)
        OP_RESET: enter_from(PH_RPRE, bus);
        OP_WRITE: begin
          shift_reg = wbyte;
          enter_from(PH_WPRE, bus);
        end
        default: begin
          shift_reg = 8'h00;
          enter_from(PH_DPRE, bus);
        end
      endcase
    end
    if (seq_phase != PH_IDLE) begin
      r.busy      = 1'b1;
      r.drive_low = (seq_phase == PH_RLOW || seq_phase == PH_WLOW || seq_phase == PH_DLOW);
      if (seq_phase == PH_RWAIT) begin
        // Presence wait has no timeout; a low bus ends it on this tick.
        if (!bus) enter_from(finish_phase(PH_RWAIT, bus), bus);
      end else begin
        ticks_left = ticks_left - 10'd1;
        if (ticks_left == 10'd0) enter_from(finish_phase(seq_phase, bus), bus);
      end
      r.done = (seq_phase == PH_IDLE);
    end
    r.rdata = last_read;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Idle length before a beat: mostly none, some short, a few long, and now and
  // then a calm stretch with no idling at all.
  function automatic int pick_gap(inout int calm);
    int roll;
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    if ($urandom_range(0, 99) < 2) begin
      calm = $urandom_range(30, 150);
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one tick beat and waits until it is taken. Entered and left at a
  // falling edge; tvalid stays high on exit so back-to-back beats need no toggle.
  task automatic push_tick(input owm_op_t op, input logic [7:0] wbyte, input logic bus,
                           input bit typed, input bus_result_t want);
    int          gap;
    bus_result_t model_out;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b00000, bus, wbyte, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // The model always advances; typed rows only replace what gets compared.
    model_out = predict_tick(op, wbyte, bus);
    tick_results.push_back(typed ? want : model_out);
    @(negedge clk);
  endtask

  // Picks a register value for a timing style. Eight-bit registers get random
  // junk in the two upper data bits, which the block has to drop.
  function automatic logic [9:0] timing_value(timing_style_t style, owm_reg_t idx);
    logic [9:0] v;
    bit         wide;
    wide = (idx == REG_RESET_LOW || idx == REG_RESET_RECOVERY);
    case (style)
      TS_ZERO:  v = 10'd0;
      TS_MAX:   v = 10'h3FF;
      TS_SMALL: v = wide ? 10'($urandom_range(0, 40)) : 10'($urandom_range(1, 6));
      default: begin
        if ($urandom_range(0, 2) == 0) v = 10'd0;
        else v = wide ? 10'($urandom_range(1, 80)) : 10'($urandom_range(1, 12));
      end
    endcase
    if (!wide && style != TS_MAX) v[9:8] = 2'($urandom_range(0, 3));
    return v;
  endfunction

  // Rewrites all eight timing registers once the block has gone quiet.
  task automatic program_timing(input timing_style_t style);
    logic [9:0] v;
    owm_reg_t   idx;
    s_tvalid <= 1'b0;
    while (tick_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    for (int i = 0; i < 8; i++) begin
      idx = owm_reg_t'(i);
      v   = timing_value(style, idx);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= v;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (idx == REG_RESET_LOW || idx == REG_RESET_RECOVERY) timing[idx] = v;
      else timing[idx] = {2'b00, v[7:0]};
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Random ticks. Commands are mostly offered whenever the bus is idle so that the
  // run spends its time inside commands; ops offered while busy are noise the block
  // must ignore. With in_turn set, commands cycle through reset, write and read.
  // The session always runs its last command to the end, leaving the block idle.
  task automatic run_session(input int tick_budget, input int cmd_budget, input bit in_turn);
    int         sent;
    int         issued;
    owm_op_t    op;
    logic       bus;
    logic [7:0] wbyte;
    sent   = 0;
    issued = 0;
    while ((sent < tick_budget && issued < cmd_budget) || seq_phase != PH_IDLE) begin
      bus   = ($urandom_range(0, 2) != 0);
      wbyte = 8'($urandom_range(0, 255));
      if (seq_phase != PH_IDLE) begin
        op = owm_op_t'($urandom_range(0, 3));
      end else if (in_turn) begin
        case (issued % 3)
          0:       op = OP_RESET;
          1:       op = OP_WRITE;
          default: op = OP_READ;
        endcase
      end else if ($urandom_range(0, 9) < 8) begin
        op = owm_op_t'($urandom_range(1, 3));
      end else begin
        op = OP_NONE;
      end
      if (seq_phase == PH_IDLE && op != OP_NONE) issued++;
      push_tick(op, wbyte, bus, 1'b0, '0);
      sent++;
    end
  endtask

  task automatic report_mismatch(input string what, input bus_result_t want,
                                 input bus_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected drive %0b busy %0b done %0b data %02h,",
               $realtime, what, want.drive_low, want.busy, want.done, want.rdata);
      $display("    got drive %0b busy %0b done %0b data %02h",
               got.drive_low, got.busy, got.done, got.rdata);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset and the main sequence
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    mismatches   = 0;
    beats_seen   = 0;
    send_calm    = 0;
    recv_calm    = 0;
    backlog_done = 1'b0;
    // Model state after reset, timing at its default values.
    seq_phase  = PH_IDLE;
    ticks_left = '0;
    shift_reg  = '0;
    bit_pos    = '0;
    last_read  = '0;
    timing[REG_RESET_LOW]      = RESET_LOW_DEF;
    timing[REG_RESET_RECOVERY] = RESET_RECOVERY_DEF;
    timing[REG_ZERO_LOW]       = {2'b00, ZERO_LOW_DEF};
    timing[REG_ONE_LOW]        = {2'b00, ONE_LOW_DEF};
    timing[REG_ONE_RELEASE]    = {2'b00, ONE_RELEASE_DEF};
    timing[REG_READ_LOW]       = {2'b00, READ_LOW_DEF};
    timing[REG_READ_SAMPLE]    = {2'b00, READ_SAMPLE_DEF};
    timing[REG_READ_TAIL]      = {2'b00, READ_TAIL_DEF};

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed part under all-zero timing.
    program_timing(TS_ZERO);
    foreach (opening_plan[r]) begin
      for (int k = 0; k < opening_plan[r].reps; k++) begin
        push_tick(opening_plan[r].op, opening_plan[r].wbyte, opening_plan[r].bus,
                  opening_plan[r].typed, opening_plan[r].want);
      end
    end

    // Random part: short timings keep commands brief so many of them fit, with
    // zeros mixed in to exercise the skipped phases.
    run_session(230, 1000, 1'b0);
    program_timing(TS_SMALL);
    run_session(240, 1000, 1'b0);
    program_timing(TS_MIXED);
    run_session(240, 1000, 1'b0);
    program_timing(TS_SMALL);
    run_session(240, 1000, 1'b0);
    program_timing(TS_MIXED);
    run_session(240, 1000, 1'b0);
    program_timing(TS_ZERO);
    run_session(240, 1000, 1'b0);

    s_tvalid <= 1'b0;
    while (tick_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold while the sender keeps
  // offering ticks, so the pipeline fills and the block stops taking input.
  initial begin
    int gap;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      gap = pick_gap(recv_calm);
      if (!backlog_done && beats_seen >= BACKLOG_AFTER) begin
        backlog_done = 1'b1;
        gap = gap + BACKLOG_HOLD;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(negedge clk);
    end
  end

  // Every accepted result beat is matched against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_beat.drive_low = m_tdata[0];
      seen_beat.busy      = m_tdata[1];
      seen_beat.done      = m_tdata[2];
      seen_beat.rdata     = m_tdata[10:3];
      beats_seen++;
      if (tick_results.size() == 0) begin
        report_mismatch("result beat with nothing expected", '0, seen_beat);
      end else begin
        wanted_beat = tick_results.pop_front();
        if (seen_beat.drive_low !== wanted_beat.drive_low ||
            seen_beat.busy      !== wanted_beat.busy ||
            seen_beat.done      !== wanted_beat.done ||
            seen_beat.rdata     !== wanted_beat.rdata) begin
          report_mismatch("result beat differs", wanted_beat, seen_beat);
        end
      end
    end
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/owm_pkg.sv
hw/rtl/owm_cfg.sv
hw/rtl/owm_seq.sv
hw/rtl/one_wire_master_byte_engine.sv
hw/rtl/owm_checker.sv
tb/tb.sv
